@@ hw/rtl/rddp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rddp_pkg
// Shared types and constants of the ramped differential drive PWM unit.
// ----------------------------------------------------------------------------
package rddp_pkg;

	// field widths
	localparam int SPEED_W    = 16;
	localparam int DUTY_W     = 13;
	localparam int STEP_W     = 15;
	localparam int OFFSET_W   = 10;
	localparam int CPP_W      = 6;
	localparam int GAIN_W     = 16;
	localparam int CMD_W      = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// default fixed-point format
	localparam int FRACTION_BITS_DEF = 8;

	// mixing and duty constants
	localparam int MIX_GAIN = 30;
	localparam int PCT_FULL = 100;
	localparam int DUTY_MAX = 8191;

	// register reset values
	localparam logic [STEP_W-1:0]   RAMP_STEP_RST = STEP_W'(1280);
	localparam logic [OFFSET_W-1:0] DUTY_OFFSET_RST = OFFSET_W'(20);
	localparam logic [CPP_W-1:0]    CPP_RST = CPP_W'(24);
	localparam logic [GAIN_W-1:0]   GAIN_RST = GAIN_W'(64);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CPP         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN   = 2'd3;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_POLAR = 2'd0,
		CMD_WHEEL = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// configuration register set
	typedef struct packed {
		logic [STEP_W-1:0]   ramp_step;
		logic [OFFSET_W-1:0] duty_offset;
		logic [CPP_W-1:0]    counts_per_percent;
		logic [GAIN_W-1:0]   wheel_base_gain;
	} cfg_t;

	// per-wheel ramp and duty result
	typedef struct packed {
		logic signed [SPEED_W-1:0] current;
		logic [DUTY_W-1:0]         forward_duty;
		logic [DUTY_W-1:0]         reverse_duty;
	} wheel_out_t;

endpackage : rddp_pkg
`default_nettype wire

@@ hw/rtl/rddp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rddp_if
// Valid/ready channels for drive requests and duty results.
// ----------------------------------------------------------------------------
interface rddp_cmd_if;
	import rddp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [SPEED_W-1:0] linear_speed;
	logic signed [SPEED_W-1:0] angular_speed;
	logic                      wheel_select;
	logic signed [SPEED_W-1:0] wheel_percent;

	modport source (
		output valid, command, linear_speed, angular_speed, wheel_select, wheel_percent,
		input  ready
	);
	modport sink (
		input  valid, command, linear_speed, angular_speed, wheel_select, wheel_percent,
		output ready
	);
endinterface : rddp_cmd_if

interface rddp_res_if;
	import rddp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [DUTY_W-1:0]         right_forward_duty;
	logic [DUTY_W-1:0]         right_reverse_duty;
	logic [DUTY_W-1:0]         left_forward_duty;
	logic [DUTY_W-1:0]         left_reverse_duty;
	logic signed [SPEED_W-1:0] right_command_now;
	logic signed [SPEED_W-1:0] left_command_now;

	modport source (
		output valid, right_forward_duty, right_reverse_duty, left_forward_duty,
		       left_reverse_duty, right_command_now, left_command_now,
		input  ready
	);
	modport sink (
		input  valid, right_forward_duty, right_reverse_duty, left_forward_duty,
		       left_reverse_duty, right_command_now, left_command_now,
		output ready
	);
endinterface : rddp_res_if
`default_nettype wire

@@ hw/rtl/rddp_mix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rddp_mix
// Polar to wheel mixing: 30*(lin +/- base*ang), saturated and rounded.
// ----------------------------------------------------------------------------
module rddp_mix #(
	parameter int FRACTION_BITS = rddp_pkg::FRACTION_BITS_DEF
) (
	input  wire logic signed [rddp_pkg::SPEED_W-1:0] linear_speed,
	input  wire logic signed [rddp_pkg::SPEED_W-1:0] angular_speed,
	input  wire logic [rddp_pkg::GAIN_W-1:0]         wheel_base_gain,
	output logic signed [rddp_pkg::SPEED_W-1:0]      right_target,
	output logic signed [rddp_pkg::SPEED_W-1:0]      left_target
);
	import rddp_pkg::*;

	localparam int TERM_W = GAIN_W + SPEED_W + 1;
	localparam int LIN_W  = SPEED_W + FRACTION_BITS;
	localparam int SUM_W  = ((LIN_W > TERM_W) ? LIN_W : TERM_W) + 1;
	localparam int V_W    = SUM_W + 5;
	localparam int FS_RAW = PCT_FULL << FRACTION_BITS;
	localparam int FS     = (FS_RAW > 32767) ? 32767 : FS_RAW;

	localparam logic signed [V_W-1:0] LIM  = V_W'(PCT_FULL) << (2 * FRACTION_BITS);
	localparam logic signed [V_W-1:0] HALF = V_W'(1) << (FRACTION_BITS - 1);
	localparam logic signed [V_W-1:0] FS_V = V_W'(FS);
	localparam logic signed [V_W-1:0] GAIN_V = V_W'(MIX_GAIN);

	logic signed [TERM_W-1:0] term;
	logic signed [SUM_W-1:0]  lin_sh;
	logic signed [SUM_W-1:0]  term_ext;
	logic signed [SUM_W-1:0]  sum_p;
	logic signed [SUM_W-1:0]  sum_m;

	// scale by the mix gain, clamp, round half up, clamp to full scale
	function automatic logic signed [SPEED_W-1:0] sat_round(input logic signed [SUM_W-1:0] s);
		logic signed [V_W-1:0] v;
		logic signed [V_W-1:0] r;
		v = V_W'(s) * GAIN_V;
		if (v > LIM) begin
			v = LIM;
		end else if (v < -LIM) begin
			v = -LIM;
		end
		r = (v + HALF) >>> FRACTION_BITS;
		if (r > FS_V) begin
			r = FS_V;
		end else if (r < -FS_V) begin
			r = -FS_V;
		end
		return r[SPEED_W-1:0];
	endfunction

	// angular term and aligned linear term
	assign term     = $signed({1'b0, wheel_base_gain}) * angular_speed;
	assign term_ext = SUM_W'(term);
	assign lin_sh   = SUM_W'(linear_speed) <<< FRACTION_BITS;
	assign sum_p    = lin_sh + term_ext;
	assign sum_m    = lin_sh - term_ext;

	assign right_target = sat_round(sum_p);
	assign left_target  = sat_round(sum_m);

endmodule : rddp_mix
`default_nettype wire

@@ hw/rtl/rddp_wheel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rddp_wheel
// One wheel: slew-limited step toward the target and forward/reverse duty.
// ----------------------------------------------------------------------------
module rddp_wheel #(
	parameter int FRACTION_BITS = rddp_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                                tick,
	input  wire logic signed [rddp_pkg::SPEED_W-1:0] current,
	input  wire logic signed [rddp_pkg::SPEED_W-1:0] target,
	input  wire rddp_pkg::cfg_t                      cfg,
	output rddp_pkg::wheel_out_t                     result
);
	import rddp_pkg::*;

	localparam int EXT_W  = SPEED_W + 1;
	localparam int PROD_W = EXT_W + CPP_W;
	localparam int D_W    = PROD_W + 1;

	logic signed [EXT_W-1:0] cur_ext;
	logic signed [EXT_W-1:0] tgt_ext;
	logic signed [EXT_W-1:0] step_ext;
	logic signed [EXT_W-1:0] up;
	logic signed [EXT_W-1:0] down;
	logic signed [EXT_W-1:0] next_ext;
	logic [EXT_W-1:0]        mag;
	logic [PROD_W-1:0]       prod;
	logic [D_W-1:0]          duty_raw;
	logic [DUTY_W-1:0]       duty;
	logic [DUTY_W-1:0]       offset;

	assign cur_ext  = EXT_W'(current);
	assign tgt_ext  = EXT_W'(target);
	assign step_ext = $signed({2'b00, cfg.ramp_step});
	assign up       = cur_ext + step_ext;
	assign down     = cur_ext - step_ext;

	// move toward the target by at most one step
	always_comb begin
		next_ext = cur_ext;
		if (tick) begin
			if (cur_ext < tgt_ext) begin
				next_ext = (up < tgt_ext) ? up : tgt_ext;
			end else if (cur_ext > tgt_ext) begin
				next_ext = (down > tgt_ext) ? down : tgt_ext;
			end
		end
	end

	// duty from the magnitude of the new command
	assign mag      = next_ext[EXT_W-1] ? EXT_W'(-next_ext) : EXT_W'(next_ext);
	assign prod     = PROD_W'(mag) * PROD_W'(cfg.counts_per_percent);
	assign duty_raw = D_W'(prod >> FRACTION_BITS) + D_W'(cfg.duty_offset);
	assign duty     = (duty_raw > D_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : duty_raw[DUTY_W-1:0];
	assign offset   = DUTY_W'(cfg.duty_offset);

	// active side by sign, bare offset on the other
	always_comb begin
		result.current = next_ext[SPEED_W-1:0];
		if (next_ext[EXT_W-1]) begin
			result.forward_duty = offset;
			result.reverse_duty = duty;
		end else begin
			result.forward_duty = duty;
			result.reverse_duty = offset;
		end
	end

endmodule : rddp_wheel
`default_nettype wire

@@ hw/rtl/ramped_differential_drive_pwm_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request enters the input register, then passes the mix,
// ramp and duty logic into the result register.
// Throughput: one request per cycle while results drain; the result register
// holds a finished result while the input register takes the next request.
// Reset: targets and commands clear to zero, registers take their defaults.
// ----------------------------------------------------------------------------
// ramped_differential_drive_pwm_unit
// Two-wheel drive with polar mixing, slew-rate limiting and duty generation.
// ----------------------------------------------------------------------------
module ramped_differential_drive_pwm_unit #(
	parameter int FRACTION_BITS = rddp_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [rddp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rddp_pkg::CFG_DATA_W-1:0]    cfg_data,
	rddp_cmd_if.sink                                cmd,
	rddp_res_if.source                              res
);
	import rddp_pkg::*;

	cfg_t cfg_q;

	logic                      valid_s1;
	logic [CMD_W-1:0]          command_s1;
	logic signed [SPEED_W-1:0] linear_speed_s1;
	logic signed [SPEED_W-1:0] angular_speed_s1;
	logic                      wheel_select_s1;
	logic signed [SPEED_W-1:0] wheel_percent_s1;

	logic signed [SPEED_W-1:0] right_target_q;
	logic signed [SPEED_W-1:0] left_target_q;
	logic signed [SPEED_W-1:0] right_current_q;
	logic signed [SPEED_W-1:0] left_current_q;
	logic signed [SPEED_W-1:0] right_target_d;
	logic signed [SPEED_W-1:0] left_target_d;

	logic signed [SPEED_W-1:0] mix_right;
	logic signed [SPEED_W-1:0] mix_left;
	logic                      tick;
	logic                      advance;
	wheel_out_t                right_out;
	wheel_out_t                left_out;

	logic       res_valid_q;
	wheel_out_t right_res_q;
	wheel_out_t left_res_q;

	// handshake: stage 1 moves on when the result register is free or drained
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign tick      = advance && (command_s1 == CMD_TICK);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step          <= RAMP_STEP_RST;
			cfg_q.duty_offset        <= DUTY_OFFSET_RST;
			cfg_q.counts_per_percent <= CPP_RST;
			cfg_q.wheel_base_gain    <= GAIN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RAMP_STEP:   cfg_q.ramp_step <= cfg_data[STEP_W-1:0];
				REG_DUTY_OFFSET: cfg_q.duty_offset <= cfg_data[OFFSET_W-1:0];
				REG_CPP:         cfg_q.counts_per_percent <= cfg_data[CPP_W-1:0];
				REG_BASE_GAIN:   cfg_q.wheel_base_gain <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1       <= cmd.command;
			linear_speed_s1  <= cmd.linear_speed;
			angular_speed_s1 <= cmd.angular_speed;
			wheel_select_s1  <= cmd.wheel_select;
			wheel_percent_s1 <= cmd.wheel_percent;
		end
	end

	rddp_mix #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_mix (
		.linear_speed    (linear_speed_s1),
		.angular_speed   (angular_speed_s1),
		.wheel_base_gain (cfg_q.wheel_base_gain),
		.right_target    (mix_right),
		.left_target     (mix_left)
	);

	// target update by command
	always_comb begin
		right_target_d = right_target_q;
		left_target_d  = left_target_q;
		unique case (command_s1)
			CMD_POLAR: begin
				right_target_d = mix_right;
				left_target_d  = mix_left;
			end
			CMD_WHEEL: begin
				if (wheel_select_s1) begin
					right_target_d = wheel_percent_s1;
				end else begin
					left_target_d = wheel_percent_s1;
				end
			end
			default: ;
		endcase
	end

	rddp_wheel #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_right (
		.tick    (tick),
		.current (right_current_q),
		.target  (right_target_q),
		.cfg     (cfg_q),
		.result  (right_out)
	);

	rddp_wheel #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_left (
		.tick    (tick),
		.current (left_current_q),
		.target  (left_target_q),
		.cfg     (cfg_q),
		.result  (left_out)
	);

	// drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_target_q  <= '0;
			left_target_q   <= '0;
			right_current_q <= '0;
			left_current_q  <= '0;
		end else if (advance) begin
			right_target_q  <= right_target_d;
			left_target_q   <= left_target_d;
			right_current_q <= right_out.current;
			left_current_q  <= left_out.current;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			right_res_q <= right_out;
			left_res_q  <= left_out;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.right_forward_duty = right_res_q.forward_duty;
	assign res.right_reverse_duty = right_res_q.reverse_duty;
	assign res.left_forward_duty  = left_res_q.forward_duty;
	assign res.left_reverse_duty  = left_res_q.reverse_duty;
	assign res.right_command_now  = right_res_q.current;
	assign res.left_command_now   = left_res_q.current;

endmodule : ramped_differential_drive_pwm_unit
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ramped differential drive PWM unit: requests
// (polar setpoints, direct wheel setpoints, ramp ticks) go in over the request
// channel, and an in-bench drive model predicts every duty result, which is
// compared field by field. Register sets are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import rddp_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int FRAC_BITS      = FRACTION_BITS_DEF;
	localparam int FULL_SCALE     = ((PCT_FULL << FRAC_BITS) > 32767) ? 32767
	                                : (PCT_FULL << FRAC_BITS);
	localparam int IDLE_PCT       = 10;
	localparam int DRAIN_CYCLES   = 6;
	localparam int STALL_AFTER    = 100;
	localparam int STALL_CYCLES   = 80;
	localparam int TIMEOUT_CYCLES = 400000;

	// command code the block leaves unused
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]          command;
		logic signed [SPEED_W-1:0] linear_speed;
		logic signed [SPEED_W-1:0] angular_speed;
		logic                      wheel_select;
		logic signed [SPEED_W-1:0] wheel_percent;
	} drive_req_t;

	typedef struct {
		logic [DUTY_W-1:0]         right_forward_duty;
		logic [DUTY_W-1:0]         right_reverse_duty;
		logic [DUTY_W-1:0]         left_forward_duty;
		logic [DUTY_W-1:0]         left_reverse_duty;
		logic signed [SPEED_W-1:0] right_command_now;
		logic signed [SPEED_W-1:0] left_command_now;
	} duty_res_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rddp_cmd_if cmd_ch ();
	rddp_res_if res_ch ();

	ramped_differential_drive_pwm_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	drive_req_t request_q[$];
	duty_res_t  duty_due_q[$];
	int         errors = 0;
	int         results_seen = 0;
	int         stall_left = 0;
	bit         no_gaps;

	// drive model state
	cfg_t drive_cfg;
	int   right_tgt = 0;
	int   left_tgt = 0;
	int   right_cur = 0;
	int   left_cur = 0;

	// clock
	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// polar mix of one wheel, saturated and rounded half up
	function automatic int mix_wheel(logic signed [SPEED_W-1:0] lin,
	                                 logic signed [SPEED_W-1:0] ang, bit plus);
		longint term;
		longint acc;
		longint lim;
		longint r;
		term = longint'(drive_cfg.wheel_base_gain) * longint'(ang);
		acc  = longint'(lin) <<< FRAC_BITS;
		acc  = plus ? acc + term : acc - term;
		acc  = acc * MIX_GAIN;
		lim  = longint'(PCT_FULL) <<< (2 * FRAC_BITS);
		if (acc > lim)
			acc = lim;
		if (acc < -lim)
			acc = -lim;
		r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > FULL_SCALE)
			r = FULL_SCALE;
		if (r < -FULL_SCALE)
			r = -FULL_SCALE;
		return int'(r);
	endfunction

	// slew-limited move of a command toward its target
	function automatic int ramp_toward(int cur, int tgt);
		int step;
		int nxt;
		step = int'(drive_cfg.ramp_step);
		if (cur < tgt) begin
			nxt = cur + step;
			cur = (nxt < tgt) ? nxt : tgt;
		end else if (cur > tgt) begin
			nxt = cur - step;
			cur = (nxt > tgt) ? nxt : tgt;
		end
		return cur;
	endfunction

	// duty counts on the driven side
	function automatic logic [DUTY_W-1:0] duty_counts(int cur);
		longint mag;
		longint d;
		mag = (cur < 0) ? -longint'(cur) : longint'(cur);
		d = ((mag * longint'(drive_cfg.counts_per_percent)) >>> FRAC_BITS)
		    + longint'(drive_cfg.duty_offset);
		if (d > DUTY_MAX)
			d = DUTY_MAX;
		return DUTY_W'(d);
	endfunction

	// update drive state for one accepted request and queue its duty result
	function automatic void step_drive(drive_req_t r);
		duty_res_t want;
		logic [DUTY_W-1:0] off;
		case (r.command)
			CMD_POLAR: begin
				right_tgt = mix_wheel(r.linear_speed, r.angular_speed, 1'b1);
				left_tgt  = mix_wheel(r.linear_speed, r.angular_speed, 1'b0);
			end
			CMD_WHEEL: begin
				if (r.wheel_select)
					right_tgt = int'(r.wheel_percent);
				else
					left_tgt = int'(r.wheel_percent);
			end
			CMD_TICK: begin
				right_cur = ramp_toward(right_cur, right_tgt);
				left_cur  = ramp_toward(left_cur, left_tgt);
			end
			default: ;
		endcase
		off = DUTY_W'(drive_cfg.duty_offset);
		want.right_forward_duty = (right_cur >= 0) ? duty_counts(right_cur) : off;
		want.right_reverse_duty = (right_cur >= 0) ? off : duty_counts(right_cur);
		want.left_forward_duty  = (left_cur >= 0) ? duty_counts(left_cur) : off;
		want.left_reverse_duty  = (left_cur >= 0) ? off : duty_counts(left_cur);
		want.right_command_now  = SPEED_W'(right_cur);
		want.left_command_now   = SPEED_W'(left_cur);
		duty_due_q.push_back(want);
	endfunction

	function automatic void push_req(logic [CMD_W-1:0] c, int lin, int ang, bit sel, int pct);
		drive_req_t r;
		r.command       = c;
		r.linear_speed  = SPEED_W'(lin);
		r.angular_speed = SPEED_W'(ang);
		r.wheel_select  = sel;
		r.wheel_percent = SPEED_W'(pct);
		request_q.push_back(r);
	endfunction

	// mostly in-range setpoints and ticks, with some full-range noise
	function automatic void push_random_req();
		int pick;
		int lin;
		int ang;
		int pct;
		pick = $urandom_range(0, 99);
		lin  = int'($urandom);
		ang  = int'($urandom);
		pct  = int'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			lin = int'($urandom_range(0, 2400)) - 1200;
			ang = int'($urandom_range(0, 2400)) - 1200;
		end
		if ($urandom_range(0, 7) != 0)
			pct = int'($urandom_range(0, 51200)) - 25600;
		if (pick < 25)
			push_req(CMD_POLAR, lin, ang, 1'($urandom), pct);
		else if (pick < 50)
			push_req(CMD_WHEEL, lin, ang, 1'($urandom), pct);
		else if (pick < 96)
			push_req(CMD_TICK, lin, ang, 1'($urandom), pct);
		else
			push_req(CMD_UNUSED, lin, ang, 1'($urandom), pct);
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// register write while the block is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_RAMP_STEP:   drive_cfg.ramp_step          = STEP_W'(value);
			REG_DUTY_OFFSET: drive_cfg.duty_offset        = OFFSET_W'(value);
			REG_CPP:         drive_cfg.counts_per_percent = CPP_W'(value);
			REG_BASE_GAIN:   drive_cfg.wheel_base_gain    = GAIN_W'(value);
			default: ;
		endcase
	endtask

	task automatic write_all(int step, int offset, int cpp, int gain);
		write_reg(REG_RAMP_STEP, step);
		write_reg(REG_DUTY_OFFSET, offset);
		write_reg(REG_CPP, cpp);
		write_reg(REG_BASE_GAIN, gain);
	endtask

	// wait for every request to be taken and every result to come back
	task automatic settle();
		do
			@(negedge clk);
		while (request_q.size() != 0 || cmd_ch.valid || duty_due_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// request driver
	always @(posedge clk) begin : driver
		bit taken;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			taken = cmd_ch.valid && cmd_ch.ready;
			if (taken)
				step_drive(request_q.pop_front());
			if (taken || !cmd_ch.valid) begin
				if (request_q.size() != 0 &&
				    (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
					cmd_ch.valid         <= 1'b1;
					cmd_ch.command       <= request_q[0].command;
					cmd_ch.linear_speed  <= request_q[0].linear_speed;
					cmd_ch.angular_speed <= request_q[0].angular_speed;
					cmd_ch.wheel_select  <= request_q[0].wheel_select;
					cmd_ch.wheel_percent <= request_q[0].wheel_percent;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor, with one long hold-off of ready
	always @(posedge clk) begin : monitor
		duty_res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (duty_due_q.size() == 0) begin
					$error("duty result arrived with none expected");
					errors++;
				end else begin
					want = duty_due_q.pop_front();
					check_field("right_forward_duty", want.right_forward_duty,
					            res_ch.right_forward_duty);
					check_field("right_reverse_duty", want.right_reverse_duty,
					            res_ch.right_reverse_duty);
					check_field("left_forward_duty", want.left_forward_duty,
					            res_ch.left_forward_duty);
					check_field("left_reverse_duty", want.left_reverse_duty,
					            res_ch.left_reverse_duty);
					check_field("right_command_now", want.right_command_now,
					            res_ch.right_command_now);
					check_field("left_command_now", want.left_command_now,
					            res_ch.left_command_now);
				end
				results_seen++;
				if (results_seen == STALL_AFTER)
					stall_left = STALL_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// watchdog
	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb: failure");
		$finish;
	end

	// stimulus and phase sequencing
	initial begin : stimulus
		no_gaps      = 1'b0;
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_RAMP_STEP;
		cfg_data     = '0;
		drive_cfg = '{RAMP_STEP_RST, DUTY_OFFSET_RST, CPP_RST, GAIN_RST};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset registers, rounding halves, saturation, raw setpoints
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_UNUSED, 32767, -32768, 1'b1, 25600);
		push_req(CMD_POLAR, 0, 1, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_POLAR, 0, -1, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_POLAR, 32767, 32767, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_POLAR, -32768, -32768, 1'b1, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_WHEEL, 0, 0, 1'b1, 25600);
		push_req(CMD_WHEEL, 0, 0, 1'b0, -25600);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_WHEEL, 0, 0, 1'b1, 32767);
		push_req(CMD_WHEEL, 0, 0, 1'b0, -32768);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_POLAR, 0, 0, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		settle();

		// upper extremes; the long result hold-off falls in here
		write_all(25600, 1023, 40, 65535);
		for (int i = 0; i < 200; i++)
			push_random_req();
		settle();

		// lower extremes: a zero ramp step freezes the commands
		write_all(0, 0, 1, 0);
		for (int i = 0; i < 80; i++)
			push_random_req();
		settle();

		// duty saturation with a large counts-per-percent
		write_all(25600, 1023, 63, 256);
		push_req(CMD_WHEEL, 0, 0, 1'b1, 32767);
		push_req(CMD_WHEEL, 0, 0, 1'b0, -32768);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		push_req(CMD_TICK, 0, 0, 1'b0, 0);
		for (int i = 0; i < 50; i++)
			push_random_req();
		settle();

		// mid-range settings, back to back with no gaps on either side
		write_all($urandom_range(1, 3000), $urandom_range(0, 1023), $urandom_range(1, 40),
		          $urandom_range(0, 65535));
		no_gaps = 1'b1;
		for (int i = 0; i < 160; i++)
			push_random_req();
		settle();
		no_gaps = 1'b0;

		// slow ramp with reset-like mixing
		write_all(1, 20, 24, 64);
		for (int i = 0; i < 100; i++)
			push_random_req();
		settle();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule : tb_top
